// ===== rtl/hex_grid_mean_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hexagonal grid mean filter
// Shorthand for clocked checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef HEX_GRID_MEAN_FILTER_ASSERT_SVH
`define HEX_GRID_MEAN_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define HGMF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define HGMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hgmf_pkg.sv =====
// ----------------------------------------------------------------------------
// hgmf_pkg
// Shared sizes, word types and helper functions of the hex grid mean filter.
// ----------------------------------------------------------------------------
package hgmf_pkg;

    // Grid limits and field widths
    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int SIZE_W      = 7;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ROW_CNT_W   = $clog2(MAX_ROWS + 2);
    localparam int HEIGHT_W    = 8;
    localparam int CNT_W       = 3;
    localparam int SUM_W       = HEIGHT_W + CNT_W;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 15;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    // Register select taken from the APB address
    typedef enum logic {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } reg_sel_t;

    // Input word
    typedef struct packed {
        logic [HEIGHT_W-1:0] height_in;
        logic                flush;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [HEIGHT_W-1:0] height_out;
        logic                last;
    } out_word_t;

    // Control of one row delay line
    typedef struct packed {
        logic             shift;
        logic [COL_W-1:0] entry_idx;
    } line_ctrl_t;

    // Neighborhood sum handed to the averaging stage
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } mean_req_t;

    // Reciprocal table: ceil(2^RECIP_SHIFT / d), exact floor for all sums here
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            3'd1:    r = 16'd32768;
            3'd2:    r = 16'd16384;
            3'd3:    r = 16'd10923;
            3'd4:    r = 16'd8192;
            3'd5:    r = 16'd6554;
            3'd6:    r = 16'd5462;
            3'd7:    r = 16'd4682;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // Limit a size register to the range 2 .. maxv
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(2)) begin
            r = SIZE_W'(2);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/hex_grid_mean_filter.sv =====
// ----------------------------------------------------------------------------
// hex_grid_mean_filter
// One smoothing pass over a height map on an offset hexagonal grid.
// ----------------------------------------------------------------------------
// Heights enter in raster order, one word per clock when the output keeps
// up: two row delay lines of MAX_COLS cells shift once per kept word and
// hold the two previous grid rows. The result for tile j leaves with input
// word j + grid_cols + 1, through the sum register and then the divide
// register; a frame is grid_rows*grid_cols tiles followed by grid_cols + 1
// flush words. Grid size is sampled from the registers at the first word of
// each frame, and a flush word at a frame start is dropped without a result;
// every other accepted word is kept.
// ----------------------------------------------------------------------------
`include "hex_grid_mean_filter_assert.svh"

module hex_grid_mean_filter (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  hgmf_pkg::in_word_t          s_data,
    // result words
    output logic                        m_valid,
    input  logic                        m_ready,
    output hgmf_pkg::out_word_t         m_data,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hgmf_pkg::ADDR_W-1:0] paddr,
    input  logic [hgmf_pkg::DATA_W-1:0] pwdata,
    output logic [hgmf_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import hgmf_pkg::*;

    // Configuration registers
    logic [SIZE_W-1:0]    grid_rows_reg;
    logic [SIZE_W-1:0]    grid_cols_reg;
    reg_sel_t             reg_sel;

    // Frame state
    logic [SIZE_W-1:0]    frame_rows_reg;
    logic [SIZE_W-1:0]    frame_cols_reg;
    logic [ROW_CNT_W-1:0] row_pos_reg;
    logic [ROW_CNT_W-1:0] row_pos_next;
    logic [COL_W-1:0]     col_pos_reg;
    logic [COL_W-1:0]     col_pos_next;
    logic [ROW_W-1:0]     out_row_reg;
    logic [ROW_W-1:0]     out_row_next;
    logic [COL_W-1:0]     out_col_reg;
    logic [COL_W-1:0]     out_col_next;

    // Window taps
    logic [HEIGHT_W-1:0]  p1_reg;
    logic [HEIGHT_W-1:0]  p2_reg;
    logic [HEIGHT_W-1:0]  q1_reg;
    logic [HEIGHT_W-1:0]  q2_reg;
    logic [HEIGHT_W-1:0]  t1_reg;
    logic [HEIGHT_W-1:0]  t2_reg;
    logic [HEIGHT_W-1:0]  a_tap;
    logic [HEIGHT_W-1:0]  b_tap;
    line_ctrl_t           line_ctrl;

    // Control
    logic                 at_start;
    logic [SIZE_W-1:0]    rows_eff;
    logic [SIZE_W-1:0]    cols_eff;
    logic                 accept;
    logic                 skip;
    logic                 take;
    logic                 has_result;
    logic                 is_last;
    logic                 mean_ready;
    mean_req_t            mean_req;
    logic                 c_gt0;
    logic                 c_lt_end;
    logic                 r_gt0;
    logic                 r_lt_end;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_sel = reg_sel_t'(paddr[ADDR_W-1]);

    always_comb begin
        case (reg_sel)
            REG_GRID_ROWS: prdata = DATA_W'(grid_rows_reg);
            REG_GRID_COLS: prdata = DATA_W'(grid_cols_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= SIZE_W'(MAX_ROWS);
            grid_cols_reg <= SIZE_W'(MAX_COLS);
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_GRID_ROWS: grid_rows_reg <= pwdata[SIZE_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= pwdata[SIZE_W-1:0];
                default:       grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    // Frame size in force for this word
    assign at_start = (row_pos_reg == '0) && (col_pos_reg == '0);
    assign rows_eff = at_start ? clamp_size(grid_rows_reg, SIZE_W'(MAX_ROWS)) : frame_rows_reg;
    assign cols_eff = at_start ? clamp_size(grid_cols_reg, SIZE_W'(MAX_COLS)) : frame_cols_reg;

    // Accept, drop and result decisions
    assign accept     = s_valid && s_ready;
    assign skip       = at_start && s_data.flush;
    assign take       = accept && !skip;
    assign has_result = (row_pos_reg != '0) &&
                        !((row_pos_reg == ROW_CNT_W'(1)) && (col_pos_reg == '0));
    assign is_last    = (SIZE_W'(out_row_reg) == rows_eff - SIZE_W'(1)) &&
                        (SIZE_W'(out_col_reg) == cols_eff - SIZE_W'(1));

    // Row delay lines: line A lags the input by one row, line B by two
    assign line_ctrl.shift     = take;
    assign line_ctrl.entry_idx = COL_W'(cols_eff - SIZE_W'(1));

    hgmf_row_line u_line_a (
        .aclk       (aclk),
        .ctrl       (line_ctrl),
        .entry_data (s_data.height_in),
        .tap_out    (a_tap)
    );

    hgmf_row_line u_line_b (
        .aclk       (aclk),
        .ctrl       (line_ctrl),
        .entry_data (a_tap),
        .tap_out    (b_tap)
    );

    // Advance the short tap registers beside the lines
    always_ff @(posedge aclk) begin
        if (take) begin
            p1_reg <= s_data.height_in;
            p2_reg <= p1_reg;
            q1_reg <= a_tap;
            q2_reg <= q1_reg;
            t1_reg <= b_tap;
            t2_reg <= t1_reg;
        end
    end

    // Grid edge flags of the tile being finished
    assign c_gt0    = (out_col_reg != '0);
    assign c_lt_end = (SIZE_W'(out_col_reg) != cols_eff - SIZE_W'(1));
    assign r_gt0    = (out_row_reg != '0);
    assign r_lt_end = (SIZE_W'(out_row_reg) != rows_eff - SIZE_W'(1));

    // Sum the in-grid neighborhood and count its members
    always_comb begin
        mean_req.sum  = SUM_W'(q1_reg);
        mean_req.cnt  = CNT_W'(1);
        mean_req.last = is_last;
        if (c_gt0) begin
            mean_req.sum = mean_req.sum + SUM_W'(q2_reg);
            mean_req.cnt = mean_req.cnt + CNT_W'(1);
        end
        if (c_lt_end) begin
            mean_req.sum = mean_req.sum + SUM_W'(a_tap);
            mean_req.cnt = mean_req.cnt + CNT_W'(1);
        end
        if (r_gt0) begin
            mean_req.sum = mean_req.sum + SUM_W'(t1_reg);
            mean_req.cnt = mean_req.cnt + CNT_W'(1);
        end
        if (r_lt_end) begin
            mean_req.sum = mean_req.sum + SUM_W'(p1_reg);
            mean_req.cnt = mean_req.cnt + CNT_W'(1);
        end
        if (out_row_reg[0]) begin
            // odd row: diagonals to the right
            if (r_gt0 && c_lt_end) begin
                mean_req.sum = mean_req.sum + SUM_W'(b_tap);
                mean_req.cnt = mean_req.cnt + CNT_W'(1);
            end
            if (r_lt_end && c_lt_end) begin
                mean_req.sum = mean_req.sum + SUM_W'(s_data.height_in);
                mean_req.cnt = mean_req.cnt + CNT_W'(1);
            end
        end else begin
            // even row: diagonals to the left
            if (r_gt0 && c_gt0) begin
                mean_req.sum = mean_req.sum + SUM_W'(t2_reg);
                mean_req.cnt = mean_req.cnt + CNT_W'(1);
            end
            if (r_lt_end && c_gt0) begin
                mean_req.sum = mean_req.sum + SUM_W'(p2_reg);
                mean_req.cnt = mean_req.cnt + CNT_W'(1);
            end
        end
    end

    // Next raster positions of the input and of the result
    always_comb begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (take) begin
            if (has_result && is_last) begin
                row_pos_next = '0;
                col_pos_next = '0;
                out_row_next = '0;
                out_col_next = '0;
            end else begin
                if (SIZE_W'(col_pos_reg) == cols_eff - SIZE_W'(1)) begin
                    col_pos_next = '0;
                    row_pos_next = row_pos_reg + ROW_CNT_W'(1);
                end else begin
                    col_pos_next = col_pos_reg + COL_W'(1);
                end
                if (has_result) begin
                    if (SIZE_W'(out_col_reg) == cols_eff - SIZE_W'(1)) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    // Hold positions and latch the frame size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            frame_rows_reg <= SIZE_W'(MAX_ROWS);
            frame_cols_reg <= SIZE_W'(MAX_COLS);
        end else begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            if (take && at_start) begin
                frame_rows_reg <= rows_eff;
                frame_cols_reg <= cols_eff;
            end
        end
    end

    // Average and output register
    hgmf_mean u_mean (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid && has_result),
        .in_ready (mean_ready),
        .req      (mean_req),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign s_ready = mean_ready;

    `HGMF_ASSERT_SAME(a_out_col_range, 1'b1, SIZE_W'(out_col_reg) < frame_cols_reg, "result column beyond frame width")
    `HGMF_ASSERT_SAME(a_frame_cols_range, 1'b1, (frame_cols_reg >= SIZE_W'(2)) && (frame_cols_reg <= SIZE_W'(MAX_COLS)), "latched frame width out of range")
    `HGMF_ASSERT_NEXT(a_frame_wrap, take && has_result && is_last, (row_pos_reg == '0) && (col_pos_reg == '0) && (out_row_reg == '0) && (out_col_reg == '0), "positions not cleared after last tile")

endmodule

// ===== rtl/hgmf_cell.sv =====
// ----------------------------------------------------------------------------
// hgmf_cell
// One height register of a row delay line: loads the line entry or its
// upstream neighbor on every shift.
// ----------------------------------------------------------------------------
module hgmf_cell (
    input  logic                          aclk,
    input  logic                          shift,
    input  logic                          take_entry,
    input  logic [hgmf_pkg::HEIGHT_W-1:0] entry_data,
    input  logic [hgmf_pkg::HEIGHT_W-1:0] nb_data,
    output logic [hgmf_pkg::HEIGHT_W-1:0] data_out
);
    import hgmf_pkg::*;

    logic [HEIGHT_W-1:0] data_reg;
    logic [HEIGHT_W-1:0] data_next;

    // Pick the entry at the active line end, else pass the neighbor along
    always_comb begin
        data_next = take_entry ? entry_data : nb_data;
    end

    // Advance on every shift, that is every accepted word that is not dropped
    always_ff @(posedge aclk) begin
        if (shift) begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule

// ===== rtl/hgmf_row_line.sv =====
// ----------------------------------------------------------------------------
// hgmf_row_line
// Programmable delay line of MAX_COLS cells. Words enter at cell
// entry_idx and leave at cell 0, so the tap lags the entry by
// entry_idx + 1 shifts.
// ----------------------------------------------------------------------------
module hgmf_row_line (
    input  logic                          aclk,
    input  hgmf_pkg::line_ctrl_t          ctrl,
    input  logic [hgmf_pkg::HEIGHT_W-1:0] entry_data,
    output logic [hgmf_pkg::HEIGHT_W-1:0] tap_out
);
    import hgmf_pkg::*;

    logic [HEIGHT_W-1:0] cell_q [MAX_COLS];

    // Build the chain; each cell hands its word toward cell 0
    for (genvar k = 0; k < MAX_COLS; k++) begin : g_chain
        logic                take_k;
        logic [HEIGHT_W-1:0] nb_k;

        assign take_k = (ctrl.entry_idx == COL_W'(k));

        if (k == MAX_COLS - 1) begin : g_end
            assign nb_k = entry_data;
        end else begin : g_mid
            assign nb_k = cell_q[k+1];
        end

        hgmf_cell u_stage (
            .aclk       (aclk),
            .shift      (ctrl.shift),
            .take_entry (take_k),
            .entry_data (entry_data),
            .nb_data    (nb_k),
            .data_out   (cell_q[k])
        );
    end

    assign tap_out = cell_q[0];

endmodule

// ===== rtl/hgmf_mean.sv =====
// ----------------------------------------------------------------------------
// hgmf_mean
// Averaging stage: registers the neighborhood sum, divides by the count
// through a reciprocal multiply and holds the result word for the output.
// ----------------------------------------------------------------------------
`include "hex_grid_mean_filter_assert.svh"

module hgmf_mean (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  hgmf_pkg::mean_req_t req,
    output logic                m_valid,
    input  logic                m_ready,
    output hgmf_pkg::out_word_t m_data
);
    import hgmf_pkg::*;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    mean_req_t                 s1_req_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    out_word_t                 out_word_reg;
    out_word_t                 out_word_next;
    logic                      out_free;
    logic                      s1_move;
    logic [SUM_W+RECIP_W-1:0]  prod;

    // Flow control between the two stages
    assign out_free = !out_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // Divide by the count: multiply by the reciprocal and drop the fraction
    always_comb begin
        prod = {{RECIP_W{1'b0}}, s1_req_reg.sum} *
               {{SUM_W{1'b0}}, recip(s1_req_reg.cnt)};
        out_word_next.height_out = prod[RECIP_SHIFT +: HEIGHT_W];
        out_word_next.last       = s1_req_reg.last;
    end

    // Next valid state of both stages
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load payload registers
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            s1_req_reg <= req;
        end
        if (s1_move) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    `HGMF_ASSERT_SAME(a_cnt_nonzero, s1_valid_reg, s1_req_reg.cnt != '0, "mean stage count is zero")
    `HGMF_ASSERT_NEXT(a_s1_kept, s1_valid_reg && out_valid_reg && !m_ready, s1_valid_reg, "sum stage word lost during stall")

endmodule

// ===== sim/hex_grid_mean_filter_tb.sv =====
// ----------------------------------------------------------------------------
// hex_grid_mean_filter_tb
// Self-checking bench for one smoothing pass over a hexagonal height map.
// ----------------------------------------------------------------------------
// Words go in through the valid/ready input channel. A scoreboard keeps its
// own copy of the grid and works out the mean of every tile as its
// neighborhood completes. Each result word is checked in order against that
// mean. A short directed part covers flat and extreme heights, flush words
// at a frame start, inside the grid and during the drain, size clamping and
// size latching. Random frames then follow under four handshake patterns,
// with grid sizes from 2 up to 64 on either axis.
// ----------------------------------------------------------------------------
module hex_grid_mean_filter_tb;
    import hgmf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_WORDS   = 360;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the mean of each tile and checks result words
    // ------------------------------------------------------------------------
    class hex_mean_board;
        logic [SIZE_W-1:0]   cfg_rows;
        logic [SIZE_W-1:0]   cfg_cols;
        int                  frame_rows;
        int                  frame_cols;
        int                  row_pos;
        int                  col_pos;
        logic [HEIGHT_W-1:0] tile_h [MAX_ROWS*MAX_COLS];
        out_word_t           pending_means[$];
        int unsigned         words_used;
        int unsigned         flushes_dropped;
        int unsigned         means_checked;
        int unsigned         frames_done;
        int unsigned         mismatches;

        function new();
            cfg_rows        = SIZE_W'(64);
            cfg_cols        = SIZE_W'(64);
            frame_rows      = MAX_ROWS;
            frame_cols      = MAX_COLS;
            row_pos         = 0;
            col_pos         = 0;
            words_used      = 0;
            flushes_dropped = 0;
            means_checked   = 0;
            frames_done     = 0;
            mismatches      = 0;
        endfunction

        // Register value as the block uses it: at least 2, at most the maximum
        function int fit_size(logic [SIZE_W-1:0] v, int maxv);
            if (v < 2) return 2;
            if (int'(v) > maxv) return maxv;
            return int'(v);
        endfunction

        function void set_reg(reg_sel_t sel, logic [SIZE_W-1:0] v);
            case (sel)
                REG_GRID_ROWS: cfg_rows = v;
                REG_GRID_COLS: cfg_cols = v;
                default: ;
            endcase
        endfunction

        // Grid size the next frame will latch
        function void size_in_use(output int rows, output int cols);
            rows = fit_size(cfg_rows, MAX_ROWS);
            cols = fit_size(cfg_cols, MAX_COLS);
        endfunction

        function bit at_frame_start();
            return row_pos == 0 && col_pos == 0;
        endfunction

        // Add one tile to the neighborhood if it lies inside the grid
        function void add_tile(int r, int c, inout int sum, inout int cnt);
            if (r < 0 || c < 0 || r >= frame_rows || c >= frame_cols) return;
            sum += tile_h[r * frame_cols + c];
            cnt += 1;
        endfunction

        // Note one accepted input word; queue the mean it completes, if any
        function void take_height(in_word_t w);
            int        tiles;
            int        idx;
            int        j;
            int        r;
            int        c;
            int        sum;
            int        cnt;
            int        off;
            out_word_t mean_w;

            // latch size at the frame start; drop a flush word there
            if (at_frame_start()) begin
                if (w.flush) begin
                    flushes_dropped++;
                    return;
                end
                frame_rows = fit_size(cfg_rows, MAX_ROWS);
                frame_cols = fit_size(cfg_cols, MAX_COLS);
            end
            words_used++;

            // store tile heights; anything past the grid is a drain word
            tiles = frame_rows * frame_cols;
            idx   = row_pos * frame_cols + col_pos;
            if (idx < tiles) tile_h[idx] = w.height_in;
            col_pos++;
            if (col_pos >= frame_cols) begin
                col_pos = 0;
                row_pos++;
            end
            if (idx < frame_cols + 1) return;

            // tile whose lower neighbors are now all known
            j   = idx - frame_cols - 1;
            r   = j / frame_cols;
            c   = j % frame_cols;
            sum = 0;
            cnt = 0;
            add_tile(r, c - 1, sum, cnt);
            add_tile(r, c, sum, cnt);
            add_tile(r, c + 1, sum, cnt);
            // odd rows sit half a tile right, so they reach one column further
            off = (r % 2 == 1) ? 0 : -1;
            for (int dr = -1; dr <= 1; dr += 2) begin
                add_tile(r + dr, c + off, sum, cnt);
                add_tile(r + dr, c + off + 1, sum, cnt);
            end
            mean_w.height_out = HEIGHT_W'(sum / cnt);
            mean_w.last       = (j == tiles - 1);
            pending_means.push_back(mean_w);

            // wrap to the next frame after the last tile
            if (j >= tiles - 1) begin
                row_pos = 0;
                col_pos = 0;
                frames_done++;
            end
        endfunction

        task report(string what);
            if (mismatches < 40) $display("MISMATCH: %s", what);
            mismatches++;
        endtask

        // Compare one result word with the oldest predicted mean
        task check_mean(out_word_t got);
            out_word_t want;
            if (pending_means.size() == 0) begin
                report($sformatf("result word height_out=%0d last=%0b with none expected",
                                 got.height_out, got.last));
                return;
            end
            want = pending_means.pop_front();
            if (got.height_out !== want.height_out) begin
                report($sformatf("result %0d: height_out %0d, expected %0d",
                                 means_checked, got.height_out, want.height_out));
            end
            if (got.last !== want.last) begin
                report($sformatf("result %0d: last %0b, expected %0b",
                                 means_checked, got.last, want.last));
            end
            means_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------------
    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_word_t             s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_word_t            m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_W-1:0]    paddr   = '0;
    logic [DATA_W-1:0]    pwdata  = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    int unsigned          send_idle_pct  = 0;
    int unsigned          recv_stall_pct = 0;
    int unsigned          cycle_count    = 0;
    int                   idle_of  [4] = '{0, 62, 0, 14};
    int                   stall_of [4] = '{0, 0, 62, 14};
    int                   open_rows[4] = '{127, 1, 64, 2};
    int                   open_cols[4] = '{0, 65, 2, 64};

    hex_mean_board sb = new();

    always #5 aclk = ~aclk;

    hex_grid_mean_filter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Check each accepted result word; stall the result channel at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_mean(m_data);
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("** hex_grid_mean_filter: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic in_word_t word_of(logic [HEIGHT_W-1:0] h, logic f);
        in_word_t w;
        w.height_in = h;
        w.flush     = f;
        return w;
    endfunction

    // Offer one word, idling first at random, and hold it until accepted
    task automatic send_word(input in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.take_height(w);
    endtask

    // Drop valid and wait until every predicted mean has come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_means.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic read_reg(input reg_sel_t sel, input logic [SIZE_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[SIZE_W-1:0] !== want) begin
            sb.report($sformatf("register %s reads %0d, expected %0d",
                                sel.name(), prdata[SIZE_W-1:0], want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write a size register, then read it back
    task automatic write_reg(input reg_sel_t sel, input logic [SIZE_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= DATA_W'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(sel, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        read_reg(sel, v);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
        wait_idle();
        write_reg(REG_GRID_ROWS, rows);
        write_reg(REG_GRID_COLS, cols);
    endtask

    // Drain whatever frame is open with flush words
    task automatic finish_frame();
        while (!sb.at_frame_start()) send_word(word_of(HEIGHT_W'($urandom_range(0, 255)), 1'b1));
    endtask

    // One frame of tiles and drain words with random content
    task automatic send_frame();
        int               rows;
        int               cols;
        int               fill;
        int               n_drain;
        logic [HEIGHT_W-1:0] h;

        sb.size_in_use(rows, cols);
        fill = $urandom_range(0, 5);
        for (int k = 0; k < rows * cols; k++) begin
            case (fill)
                0:       h = '0;
                1:       h = '1;
                2:       h = (k % 2 == 0) ? '1 : '0;
                default: h = HEIGHT_W'($urandom_range(0, 255));
            endcase
            // a flush bit inside the grid is a plain tile
            send_word(word_of(h, (k != 0) && ($urandom_range(0, 9) == 0)));
        end
        // cut the drain short now and then; later words finish it
        n_drain = cols + 1;
        if ($urandom_range(0, 9) == 0) n_drain = $urandom_range(0, cols);
        for (int k = 0; k < n_drain; k++) begin
            send_word(word_of(HEIGHT_W'($urandom_range(0, 255)), $urandom_range(0, 6) != 0));
        end
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return SIZE_W'($urandom_range(0, 1));
            1:       return SIZE_W'(2);
            default: return SIZE_W'($urandom_range(2, 9));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase_start;
        bit          opener;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        read_reg(REG_GRID_ROWS, SIZE_W'(64));
        read_reg(REG_GRID_COLS, SIZE_W'(64));

        // 2x2: flush at frame start, flush inside the grid, tile during drain
        set_size(SIZE_W'(2), SIZE_W'(2));
        send_word(word_of(8'd77, 1'b1));
        send_word(word_of(8'd255, 1'b0));
        send_word(word_of(8'd0, 1'b1));
        send_word(word_of(8'd255, 1'b0));
        send_word(word_of(8'd255, 1'b0));
        send_word(word_of(8'd255, 1'b1));
        send_word(word_of(8'd200, 1'b0));
        send_word(word_of(8'd0, 1'b1));

        // 3x2 frame; a size write after its first words waits for the next frame
        set_size(SIZE_W'(3), SIZE_W'(2));
        send_word(word_of(8'd0, 1'b0));
        send_word(word_of(8'd255, 1'b0));
        set_size(SIZE_W'(127), SIZE_W'(3));
        send_word(word_of(8'd0, 1'b0));
        send_word(word_of(8'd255, 1'b0));
        send_word(word_of(8'd255, 1'b0));
        send_word(word_of(8'd0, 1'b0));
        repeat (3) send_word(word_of(8'd0, 1'b1));

        // sizes below range run as 2x2; all heights at full scale
        set_size(SIZE_W'(1), SIZE_W'(1));
        repeat (4) send_word(word_of(8'd255, 1'b0));
        repeat (3) send_word(word_of(8'd255, 1'b1));

        // random frames under each handshake pattern; each opens with an extreme size
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_of[ph];
            recv_stall_pct = stall_of[ph];
            phase_start    = sb.words_used;
            opener         = 1'b1;
            while (sb.words_used - phase_start < PHASE_WORDS) begin
                if (opener || $urandom_range(0, 2) == 0) begin
                    finish_frame();
                    if (opener) begin
                        set_size(SIZE_W'(open_rows[ph]), SIZE_W'(open_cols[ph]));
                    end else begin
                        set_size(pick_size(), pick_size());
                    end
                    opener = 1'b0;
                end
                // stray flush word, dropped when it lands on a frame start
                if ($urandom_range(0, 9) == 0) begin
                    send_word(word_of(HEIGHT_W'($urandom_range(0, 255)), 1'b1));
                end
                send_frame();
            end
        end
        finish_frame();
        wait_idle();

        $display("Ran %0d frames from 2x2 to 64-wide and 64-tall grids: %0d words used,",
                 sb.frames_done, sb.words_used);
        $display("%0d flush words dropped, %0d means checked, %0d mismatches",
                 sb.flushes_dropped, sb.means_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_means.size() == 0) begin
            $display("** hex_grid_mean_filter: PASSED **");
        end else begin
            $display("** hex_grid_mean_filter: FAILED **");
        end
        $finish;
    end

endmodule
